[rtl/core/emc_pkg.sv]
// ----------------------------------------------------------------------------
// Euclidean MST cost package
// Shared item types, field widths, input modes and controller commands.
// ----------------------------------------------------------------------------
package emc_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_BITS_DEF  = 20;
  localparam int COORD_W         = 20;
  localparam int LINK_W          = 7;
  localparam int TOTAL_W         = 35;
  localparam int PCOUNT_W        = 7;

  localparam logic [1:0] MODE_POINT   = 2'd0;
  localparam logic [1:0] MODE_LINK    = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [LINK_W-1:0]  link_a;
    logic [LINK_W-1:0]  link_b;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]  total_cost_q8;
    logic [PCOUNT_W-1:0] points_used;
    logic                input_error;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_LOAD       = 4'd1,
    OP_LINK_CHK   = 4'd2,
    OP_LINK_RD    = 4'd3,
    OP_LINK_LATCH = 4'd4,
    OP_RELABEL    = 4'd5,
    OP_CMP_INIT   = 4'd6,
    OP_LOADU      = 4'd7,
    OP_LATCH      = 4'd8,
    OP_SWEEP      = 4'd9,
    OP_SQ_START   = 4'd10,
    OP_SQ_WAIT    = 4'd11,
    OP_ACC        = 4'd12,
    OP_DONE       = 4'd13
  } dp_op_t;

  typedef struct packed {
    logic link_bad;
    logic few_points;
    logic relabel_done;
    logic sweep_done;
    logic sq_busy;
    logic last_point;
    logic out_full;
  } dp_status_t;

endpackage

[rtl/core/emc_sqrt.sv]
// ----------------------------------------------------------------------------
// Edge length unit
// Restoring square root of the squared distance scaled by 2^16, one result
// bit per cycle, giving the length in Q.8.
// ----------------------------------------------------------------------------
module emc_sqrt #(
  parameter int D2W = 41,
  localparam int QW = (D2W + 17) / 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [D2W-1:0] d2,
  output logic           busy,
  output logic [QW-1:0]  root
);
  localparam int RADW = 2 * QW;
  localparam int SW   = $clog2(QW + 1);

  logic [RADW-1:0] rad;
  logic [QW-1:0]   rem;
  logic [SW-1:0]   steps;
  logic [QW+1:0]   rem_sh;
  logic [QW+1:0]   trial;
  logic            ge;

  assign rem_sh = {rem, rad[RADW-1:RADW-2]};
  assign trial  = {root, 2'b01};
  assign ge     = rem_sh >= trial;
  assign busy   = steps != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      rad   <= RADW'({d2, 16'h0000});
      rem   <= '0;
      root  <= '0;
      steps <= SW'(QW);
    end else if (busy) begin
      rad   <= rad << 2;
      rem   <= ge ? QW'(rem_sh - trial) : QW'(rem_sh);
      root  <= {root[QW-2:0], ge};
      steps <= steps - SW'(1);
    end
  end

endmodule

[rtl/core/emc_dp.sv]
// ----------------------------------------------------------------------------
// Euclidean MST cost datapath
// Point and label memories, Prim key memory with its distance pipeline,
// the length unit, the running total and the result register.
// ----------------------------------------------------------------------------
module emc_dp #(
  parameter int MAX_POINTS = emc_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = emc_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  emc_pkg::dp_op_t       op,
  input  emc_pkg::in_item_t     in_item,
  output emc_pkg::dp_status_t   status,
  output logic                  result_valid,
  input  logic                  result_stall,
  output emc_pkg::out_item_t    result
);
  import emc_pkg::*;

  localparam int IDXW = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int CW   = COORD_BITS;
  localparam int D2W  = 2 * CW + 1;
  localparam int QW   = (D2W + 17) / 2;
  localparam int LW   = (CNTW > LINK_W) ? CNTW : LINK_W;

  logic [CW-1:0]   px [MAX_POINTS];
  logic [CW-1:0]   py [MAX_POINTS];
  logic [IDXW-1:0] comp [MAX_POINTS];
  logic [D2W-1:0]  key [MAX_POINTS];

  logic [CW-1:0]   rd_x, rd_y;
  logic [IDXW-1:0] rd_c, rd_b;
  logic [D2W-1:0]  rd_k;

  logic [CNTW-1:0] cnt, idx, added;
  logic            err, first;
  logic [IDXW-1:0] ia, ib, la, lb, u, uc, best_v;
  logic [CW-1:0]   ux, uy;
  logic [MAX_POINTS-1:0] intree;
  logic [TOTAL_W-1:0] total;
  logic [D2W-1:0]  best_key;
  logic            best_found;

  logic            p1_valid, p1_skip;
  logic [IDXW-1:0] p1_idx;
  logic            p2_valid, p2_skip, p2_same;
  logic [IDXW-1:0] p2_idx;
  logic [CW-1:0]   p2_dx, p2_dy;
  logic [D2W-1:0]  p2_key;
  logic            p3_valid, p3_skip, p3_same;
  logic [IDXW-1:0] p3_idx;
  logic [2*CW-1:0] p3_sx, p3_sy;
  logic [D2W-1:0]  p3_key;

  logic [IDXW-1:0] raddr, comp_wa, comp_wd;
  logic            comp_we, full, issue, kwr;
  logic [D2W-1:0]  cand, new_key;
  logic [CW-1:0]   xin, yin;
  logic [LW-1:0]   a_ext, b_ext, cnt_ext;
  logic            sq_busy;
  logic [QW-1:0]   root;

  assign xin     = CW'(in_item.x_coord);
  assign yin     = CW'(in_item.y_coord);
  assign full    = cnt == CNTW'(MAX_POINTS);
  assign a_ext   = LW'(in_item.link_a);
  assign b_ext   = LW'(in_item.link_b);
  assign cnt_ext = LW'(cnt);
  assign issue   = (op == OP_SWEEP || op == OP_RELABEL) && (idx < cnt);

  always_comb begin
    unique case (op)
      OP_LINK_RD: raddr = ia;
      OP_LOADU:   raddr = u;
      default:    raddr = idx[IDXW-1:0];
    endcase
  end

  always_comb begin
    comp_we = 1'b0;
    comp_wa = p1_idx;
    comp_wd = la;
    if (op == OP_LOAD && !full) begin
      comp_we = 1'b1;
      comp_wa = cnt[IDXW-1:0];
      comp_wd = cnt[IDXW-1:0];
    end else if (op == OP_RELABEL && p1_valid && rd_c == lb) begin
      comp_we = 1'b1;
    end
  end

  assign cand    = p3_same ? '0 : ({1'b0, p3_sx} + {1'b0, p3_sy});
  assign new_key = (!first && p3_key < cand) ? p3_key : cand;
  assign kwr     = p3_valid && !p3_skip;

  always_ff @(posedge clk) begin
    rd_x <= px[raddr];
    rd_y <= py[raddr];
    rd_c <= comp[raddr];
    rd_k <= key[raddr];
    rd_b <= comp[ib];
    if (op == OP_LOAD && !full) begin
      px[cnt[IDXW-1:0]] <= xin;
      py[cnt[IDXW-1:0]] <= yin;
    end
    if (comp_we) begin
      comp[comp_wa] <= comp_wd;
    end
    if (kwr) begin
      key[p3_idx] <= new_key;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx  <= idx[IDXW-1:0];
    p1_skip <= intree[idx[IDXW-1:0]];
    p2_idx  <= p1_idx;
    p2_skip <= p1_skip;
    p2_dx   <= (rd_x > ux) ? rd_x - ux : ux - rd_x;
    p2_dy   <= (rd_y > uy) ? rd_y - uy : uy - rd_y;
    p2_same <= rd_c == uc;
    p2_key  <= rd_k;
    p3_idx  <= p2_idx;
    p3_skip <= p2_skip;
    p3_sx   <= (2*CW)'(p2_dx) * (2*CW)'(p2_dx);
    p3_sy   <= (2*CW)'(p2_dy) * (2*CW)'(p2_dy);
    p3_same <= p2_same;
    p3_key  <= p2_key;
    if (kwr && (!best_found || new_key < best_key)) begin
      best_found <= 1'b1;
      best_key   <= new_key;
      best_v     <= p3_idx;
    end
    if (op == OP_LATCH) begin
      best_found <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      err          <= 1'b0;
      result_valid <= 1'b0;
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      p3_valid     <= 1'b0;
    end else begin
      p1_valid <= issue;
      p2_valid <= p1_valid && op == OP_SWEEP;
      p3_valid <= p2_valid;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (issue) begin
        idx <= idx + CNTW'(1);
      end
      unique case (op)
        OP_LOAD: begin
          if (full) begin
            err <= 1'b1;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        OP_LINK_CHK: begin
          if (status.link_bad) begin
            err <= 1'b1;
          end
          ia <= IDXW'(a_ext - LW'(1));
          ib <= IDXW'(b_ext - LW'(1));
        end
        OP_LINK_LATCH: begin
          la  <= rd_c;
          lb  <= rd_b;
          idx <= '0;
        end
        OP_CMP_INIT: begin
          u      <= '0;
          intree <= MAX_POINTS'(1);
          added  <= CNTW'(1);
          total  <= '0;
          first  <= 1'b1;
        end
        OP_LATCH: begin
          ux  <= rd_x;
          uy  <= rd_y;
          uc  <= rd_c;
          idx <= '0;
        end
        OP_ACC: begin
          total          <= total + TOTAL_W'(root);
          intree[best_v] <= 1'b1;
          u              <= best_v;
          added          <= added + CNTW'(1);
          first          <= 1'b0;
        end
        OP_DONE: begin
          result_valid         <= 1'b1;
          result.total_cost_q8 <= total;
          result.points_used   <= PCOUNT_W'(cnt);
          result.input_error   <= err;
          cnt                  <= '0;
          err                  <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  emc_sqrt #(.D2W(D2W)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (op == OP_SQ_START),
    .d2    (best_key),
    .busy  (sq_busy),
    .root  (root)
  );

  always_comb begin
    status.link_bad     = a_ext == '0 || b_ext == '0 || a_ext > cnt_ext || b_ext > cnt_ext;
    status.few_points   = cnt < CNTW'(2);
    status.relabel_done = idx == cnt && !p1_valid;
    status.sweep_done   = idx == cnt && !p1_valid && !p2_valid && !p3_valid;
    status.sq_busy      = sq_busy;
    status.last_point   = (added + CNTW'(1)) == cnt;
    status.out_full     = result_valid;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNTW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(op == OP_DONE))
    else $error("result raised without a finished computation");

  a_acc_has_best: assert property (@(posedge clk) disable iff (rst)
    op == OP_ACC |-> best_found && !intree[best_v])
    else $error("tree grown without a fresh nearest point");

endmodule

[rtl/core/emc_ctrl.sv]
// ----------------------------------------------------------------------------
// Euclidean MST cost controller
// Sequences loads, link merges and the Prim passes of a computation.
// ----------------------------------------------------------------------------
module emc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_mode,
  output logic                in_stall,
  output emc_pkg::dp_op_t     op,
  input  emc_pkg::dp_status_t status
);
  import emc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE       = 11'b000_0000_0001,
    S_LINK_RD    = 11'b000_0000_0010,
    S_LINK_LATCH = 11'b000_0000_0100,
    S_RELABEL    = 11'b000_0000_1000,
    S_LOADU      = 11'b000_0001_0000,
    S_LATCH      = 11'b000_0010_0000,
    S_SWEEP      = 11'b000_0100_0000,
    S_SQ_START   = 11'b000_1000_0000,
    S_SQ_WAIT    = 11'b001_0000_0000,
    S_ACC        = 11'b010_0000_0000,
    S_DONE       = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE) || (status.out_full && in_mode == MODE_COMPUTE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_POINT: op = OP_LOAD;
            MODE_LINK: begin
              op = OP_LINK_CHK;
              if (!status.link_bad) begin
                state_next = S_LINK_RD;
              end
            end
            MODE_COMPUTE: begin
              op         = OP_CMP_INIT;
              state_next = status.few_points ? S_DONE : S_LOADU;
            end
            default: op = OP_NONE;
          endcase
        end
      end
      S_LINK_RD: begin
        op         = OP_LINK_RD;
        state_next = S_LINK_LATCH;
      end
      S_LINK_LATCH: begin
        op         = OP_LINK_LATCH;
        state_next = S_RELABEL;
      end
      S_RELABEL: begin
        op = OP_RELABEL;
        if (status.relabel_done) begin
          state_next = S_IDLE;
        end
      end
      S_LOADU: begin
        op         = OP_LOADU;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        op         = OP_LATCH;
        state_next = S_SWEEP;
      end
      S_SWEEP: begin
        op = OP_SWEEP;
        if (status.sweep_done) begin
          state_next = S_SQ_START;
        end
      end
      S_SQ_START: begin
        op         = OP_SQ_START;
        state_next = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        op = OP_SQ_WAIT;
        if (!status.sq_busy) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        op         = OP_ACC;
        state_next = status.last_point ? S_DONE : S_LOADU;
      end
      S_DONE: begin
        op         = OP_DONE;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/euclidean_mst_cost.sv]
// ----------------------------------------------------------------------------
// Euclidean minimum spanning tree cost
// Collects points and existing links, then returns the Q.8 length of the
// cheapest set of extra edges that connects all points.
//
//   Channel  Direction  Payload      Handshake
//   in       receive    in_item_t    in_valid / in_stall
//   out      send       out_item_t   out_valid / out_stall
//
// A link runs a relabel pass over the label memory for the N points held.
// A computation runs one pass over the key memory plus one bit-serial
// square root for each point added to the tree.
// Reset is synchronous; after it the block holds no points.
// A compute request waits while an earlier result is still held on out.
// ----------------------------------------------------------------------------
module euclidean_mst_cost #(
  parameter int MAX_POINTS = emc_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = emc_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  emc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output emc_pkg::out_item_t out_data
);
  import emc_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  emc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .op       (op),
    .status   (status)
  );

  emc_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .in_item      (in_data),
    .status       (status),
    .result_valid (out_valid),
    .result_stall (out_stall),
    .result       (out_data)
  );

endmodule
